// ===== rtl/cda_pkg.sv =====
// Package for the calendar date arithmetic unit: opcodes, status codes,
// field widths and calendar tables. No dependencies.
`default_nettype none
package cda_pkg;
    localparam int unsigned FirstYear  = 1950;
    localparam int unsigned LastYear   = 2049;
    localparam int unsigned LastDayNum = 36524;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIFF = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DM   = 2'd1,
        ST_BAD_YEAR = 2'd2,
        ST_BAD_DAY  = 2'd3
    } t_status;

    typedef struct packed {
        logic start;
        logic [1:0] op;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2: r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1: r = 9'd0;
            4'd2: r = 9'd31;
            4'd3: r = 9'd59;
            4'd4: r = 9'd90;
            4'd5: r = 9'd120;
            4'd6: r = 9'd151;
            4'd7: r = 9'd181;
            4'd8: r = 9'd212;
            4'd9: r = 9'd243;
            4'd10: r = 9'd273;
            4'd11: r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] check_date(input logic [4:0] d, input logic [3:0] m,
                                              input logic [11:0] y);
        logic [1:0] r;
        r = ST_OK;
        if (d == 5'd0 || m == 4'd0 || m > 4'd12)
            r = ST_BAD_DM;
        else if (y < 12'(FirstYear) || y > 12'(LastYear))
            r = ST_BAD_YEAR;
        else if (d > month_len(m, y[1:0] == 2'd0))
            r = ST_BAD_DAY;
        return r;
    endfunction

    // days since 1 Jan 1950; yo is year minus 1950 (0..99)
    function automatic logic [15:0] day_number(input logic [4:0] d, input logic [3:0] m,
                                               input logic [6:0] yo);
        logic [15:0] n;
        logic leap;
        leap = yo[1:0] == 2'd2;
        n = 16'(yo) * 16'd365 + 16'((7'(yo) + 7'd1) >> 2);
        n = n + 16'(month_start(m)) + 16'(d) - 16'd1;
        if (m > 4'd2 && leap)
            n = n + 16'd1;
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/cda_datapath.sv =====
// Datapath of the calendar date unit: stored date, day stepper, weekday
// counter and difference. Depends on cda_pkg.
`default_nettype none
module cda_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cda_pkg::t_cmd i_cmd,
    input  wire logic [4:0]    i_day,
    input  wire logic [3:0]    i_month,
    input  wire logic [11:0]   i_year,
    input  wire logic [16:0]   i_offset,
    output cda_pkg::t_sts      o_sts,
    output logic [4:0]         o_day,
    output logic [3:0]         o_month,
    output logic [11:0]        o_year,
    output logic [2:0]         o_weekday,
    output logic [15:0]        o_between,
    output logic [1:0]         o_status
);
    import cda_pkg::*;

    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [6:0]  r_yo;
    logic [2:0]  r_wd;
    logic [16:0] r_rem;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_between;
    logic [1:0]  r_status;
    logic [15:0] r_here;
    logic [1:0]  r_phase;

    logic        leap;
    logic [4:0]  mlen;
    logic [4:0]  prev_len;
    logic [3:0]  prev_m;
    logic        neg;
    logic [16:0] mag;
    logic [17:0] target;
    logic [1:0]  chk;
    logic [15:0] other;

    assign leap     = r_yo[1:0] == 2'd2;
    assign mlen     = month_len(r_month, leap);
    assign prev_m   = (r_month == 4'd1) ? 4'd12 : r_month - 4'd1;
    assign prev_len = month_len(prev_m, (r_month == 4'd1) ? (r_yo[1:0] == 2'd3) : leap);
    assign neg      = r_rem[16];
    assign mag      = neg ? (~r_rem + 17'd1) : r_rem;
    assign target   = {2'b00, r_here} + {i_offset[16], i_offset};
    assign chk      = check_date(i_day, i_month, i_year);
    assign other    = day_number(i_day, i_month, 7'(i_year - 12'(FirstYear)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day <= 5'd1; r_month <= 4'd1; r_yo <= 7'd0; r_wd <= 3'd7;
            r_busy <= 1'b0; r_done <= 1'b0; r_phase <= 2'd0;
            r_between <= 16'd0; r_status <= ST_OK; r_rem <= 17'd0; r_here <= 16'd0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_between <= 16'd0;
                r_status  <= ST_OK;
                r_here    <= day_number(r_day, r_month, r_yo);
                r_phase   <= 2'd1;
                r_busy    <= 1'b1;
            end else if (r_busy && r_phase == 2'd1) begin
                r_phase <= 2'd2;
                unique case (t_opcode'(i_cmd.op))
                    OP_LOAD: begin
                        r_status <= chk;
                        if (chk == ST_OK) begin
                            // weekday via difference to current, reuse stepper
                            r_rem <= 17'(other) - 17'(r_here);
                        end else r_rem <= 17'd0;
                    end
                    OP_ADD: begin
                        if (target[17] || target > 18'(LastDayNum)) begin
                            r_status <= ST_BAD_YEAR; r_rem <= 17'd0;
                        end else r_rem <= i_offset;
                    end
                    OP_DIFF: begin
                        r_status <= chk;
                        r_rem <= 17'd0;
                        if (chk == ST_OK)
                            r_between <= (other > r_here) ? other - r_here : r_here - other;
                    end
                    default: r_rem <= 17'd0;
                endcase
            end else if (r_busy && r_phase == 2'd2) begin
                if (mag == 17'd0) begin
                    r_busy <= 1'b0; r_done <= 1'b1; r_phase <= 2'd0;
                end else if (!neg && mag >= 17'd7 && {1'b0, r_day} + 6'd7 <= {1'b0, mlen}) begin
                    r_day <= r_day + 5'd7; r_rem <= r_rem - 17'd7;
                end else if (neg && mag >= 17'd7 && r_day > 5'd7) begin
                    r_day <= r_day - 5'd7; r_rem <= r_rem + 17'd7;
                end else if (!neg) begin
                    r_rem <= r_rem - 17'd1;
                    r_wd  <= (r_wd == 3'd7) ? 3'd1 : r_wd + 3'd1;
                    if (r_day == mlen) begin
                        r_day <= 5'd1;
                        if (r_month == 4'd12) begin
                            r_month <= 4'd1; r_yo <= r_yo + 7'd1;
                        end else r_month <= r_month + 4'd1;
                    end else r_day <= r_day + 5'd1;
                end else begin
                    r_rem <= r_rem + 17'd1;
                    r_wd  <= (r_wd == 3'd1) ? 3'd7 : r_wd - 3'd1;
                    if (r_day == 5'd1) begin
                        r_day <= prev_len; r_month <= prev_m;
                        if (r_month == 4'd1) r_yo <= r_yo - 7'd1;
                    end else r_day <= r_day - 5'd1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_day      = r_day;
    assign o_month    = r_month;
    assign o_year     = 12'(r_yo) + 12'(FirstYear);
    assign o_weekday  = r_wd;
    assign o_between  = r_between;
    assign o_status   = r_status;

    a_wd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wd != 3'd0) else $error("weekday zero");
    a_day_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day != 5'd0 && r_day <= mlen) else $error("stored day invalid");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
endmodule
`default_nettype wire

// ===== rtl/cda_ctrl.sv =====
// Controller of the calendar date unit: input capture, command issue and
// output register handshake. Depends on cda_pkg.
`default_nettype none
module cda_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_op,
    input  wire cda_pkg::t_sts i_sts,
    output cda_pkg::t_cmd      o_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);
    import cda_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;
    t_state     r_state;
    logic [1:0] r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_op <= i_op; r_state <= S_RUN;
                end
                S_RUN: if (i_sts.done) r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_cmd.start = r_state == S_IDLE && i_in_valid;
    assign o_cmd.op    = r_op;
    assign o_out_valid = r_state == S_OUT;
endmodule
`default_nettype wire

// ===== rtl/calendar_date_arithmetic_unit.sv =====
// Calendar date unit: load, add day offset, difference. One transaction at a time.
// The result follows accept after setup and the stepper moves: whole weeks
// inside a month, then single days.
// Load walks to the new date the same way; difference and errors take no moves.
// Next transaction is accepted the cycle after the result is taken.
// Synchronous active-low reset gives 1 Jan 1950, a Sunday. Depends on cda_pkg.
`default_nettype none
module calendar_date_arithmetic_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[1:0], in_day[6:2], in_month[10:7], in_year[22:11], day_offset[39:23]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_day[4:0], out_month[8:5], out_year[20:9], weekday[23:21],
    // days_between[39:24], status[41:40]
    output logic [47:0]      m_axis_tdata
);
    import cda_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic        in_ready;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    logic [2:0]  wd;
    logic [15:0] btw;
    logic [1:0]  st;
    logic [39:0] r_in;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && in_ready) r_in <= s_axis_tdata;
    end

    cda_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(in_ready),
        .i_op(s_axis_tdata[1:0]), .i_sts(sts), .o_cmd(cmd),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready)
    );

    cda_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_day(r_in[6:2]), .i_month(r_in[10:7]), .i_year(r_in[22:11]),
        .i_offset(r_in[39:23]), .o_sts(sts),
        .o_day(d), .o_month(m), .o_year(y), .o_weekday(wd),
        .o_between(btw), .o_status(st)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {6'd0, st, btw, wd, y, m, d};
endmodule
`default_nettype wire

// ===== tb/tb_calendar_date_arithmetic_unit.sv =====
// Testbench for calendar_date_arithmetic_unit: directed table then random transactions,
// each result checked against an in-bench calendar predictor. Depends on cda_pkg.
`timescale 1ns / 100ps
module tb_calendar_date_arithmetic_unit;
    import cda_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] between;
        logic [2:0]  wday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_res;

    typedef struct {
        t_opcode    op;
        logic [4:0] day;
        logic [3:0] month;
        logic [11:0] year;
        int         offset;
        bit         has_exp;
        t_status    exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode, in_day, in_month, in_year, day_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_day, out_month, out_year, weekday, days_between, status

    calendar_date_arithmetic_unit dut (.*);

    int unsigned date_day, date_month, date_year;
    t_res        expected_q[$];
    t_status     status_check_q[$];
    int          n_fail;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000ms;
        $display("simulation failed");
        $finish;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    function automatic t_status date_status(int unsigned d, int unsigned m, int unsigned y);
        if (d == 0 || m == 0 || m > 12) return ST_BAD_DM;
        if (y < 1950 || y > 2049) return ST_BAD_YEAR;
        if (d > days_in_month(m, y)) return ST_BAD_DAY;
        return ST_OK;
    endfunction

    function automatic int serial_day(int unsigned d, int unsigned m, int unsigned y);
        int n;
        n = 0;
        for (int unsigned yy = 1950; yy < y; yy++) n += leap_year(yy) ? 366 : 365;
        for (int unsigned mm = 1; mm < m; mm++) n += days_in_month(mm, y);
        return n + d - 1;
    endfunction

    function automatic t_res predict_date_op(t_opcode op, int unsigned d, int unsigned m,
                                             int unsigned y, int offset);
        t_res r;
        int   here, target, other, len;
        t_status st;
        st = ST_OK;
        r.between = '0;
        here = serial_day(date_day, date_month, date_year);
        case (op)
            OP_LOAD: begin
                st = date_status(d, m, y);
                if (st == ST_OK) begin
                    date_day = d; date_month = m; date_year = y;
                end
            end
            OP_ADD: begin
                target = here + offset;
                if (target < 0 || target > 36524) begin
                    st = ST_BAD_YEAR;
                end else begin
                    date_year = 1950;
                    len = leap_year(date_year) ? 366 : 365;
                    while (target >= len) begin
                        target -= len;
                        date_year++;
                        len = leap_year(date_year) ? 366 : 365;
                    end
                    date_month = 1;
                    while (target >= days_in_month(date_month, date_year)) begin
                        target -= days_in_month(date_month, date_year);
                        date_month++;
                    end
                    date_day = target + 1;
                end
            end
            OP_DIFF: begin
                st = date_status(d, m, y);
                if (st == ST_OK) begin
                    other = serial_day(d, m, y);
                    r.between = 16'((other > here) ? other - here : here - other);
                end
            end
            default: ;
        endcase
        here = serial_day(date_day, date_month, date_year);
        r.day = 5'(date_day);
        r.month = 4'(date_month);
        r.year = 12'(date_year);
        r.wday = 3'(((here + 6) % 7) + 1);
        r.status = st;
        return r;
    endfunction

    task automatic send_op(t_opcode op, logic [4:0] d, logic [3:0] m, logic [11:0] y,
                           int offset, bit has_exp, t_status exp_st);
        logic [16:0] off_bits;
        off_bits = 17'(offset);
        expected_q.push_back(predict_date_op(op, d, m, y, offset));
        status_check_q.push_back(has_exp ? exp_st : t_status'(expected_q[$].status));
        s_axis_tdata  <= {off_bits, y, m, d, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    // receiver stall pattern
    initial begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        @(negedge i_clk);
        forever begin
            phase++;
            if ((phase / 64) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        t_status st_want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[41:0]);
            if (expected_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                st_want = status_check_q.pop_front();
                if (got !== want || got.status !== st_want || m_axis_tdata[47:42] !== '0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"mismatch: exp d%0d m%0d y%0d w%0d b%0d s%0d (tbl s%0d)",
                                  " got d%0d m%0d y%0d w%0d b%0d s%0d"},
                                 want.day, want.month, want.year, want.wday, want.between,
                                 want.status, st_want, got.day, got.month, got.year,
                                 got.wday, got.between, got.status);
                end
            end
        end
    end

    t_row dir_table[] = '{
        '{OP_ADD,  5'd0,  4'd0,  12'd0,    0,     1'b1, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   -1,     1'b1, ST_BAD_YEAR},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   36524,  1'b1, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   1,      1'b1, ST_BAD_YEAR},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,  -36524,  1'b1, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   40000,  1'b1, ST_BAD_YEAR},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,  -40000,  1'b1, ST_BAD_YEAR},
        '{OP_LOAD, 5'd0,  4'd5,  12'd2000, 0,     1'b1, ST_BAD_DM},
        '{OP_LOAD, 5'd5,  4'd0,  12'd2000, 0,     1'b1, ST_BAD_DM},
        '{OP_LOAD, 5'd31, 4'd15, 12'd4095, 0,     1'b1, ST_BAD_DM},
        '{OP_LOAD, 5'd1,  4'd1,  12'd1949, 0,     1'b1, ST_BAD_YEAR},
        '{OP_LOAD, 5'd1,  4'd1,  12'd2050, 0,     1'b1, ST_BAD_YEAR},
        '{OP_LOAD, 5'd1,  4'd1,  12'd0,    0,     1'b1, ST_BAD_YEAR},
        '{OP_LOAD, 5'd31, 4'd4,  12'd2000, 0,     1'b1, ST_BAD_DAY},
        '{OP_LOAD, 5'd30, 4'd2,  12'd2000, 0,     1'b1, ST_BAD_DAY},
        '{OP_LOAD, 5'd29, 4'd2,  12'd2001, 0,     1'b1, ST_BAD_DAY},
        '{OP_LOAD, 5'd29, 4'd2,  12'd2000, 0,     1'b1, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,    1,     1'b0, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   -366,   1'b0, ST_OK},
        '{OP_DIFF, 5'd31, 4'd12, 12'd2049, 0,     1'b0, ST_OK},
        '{OP_DIFF, 5'd1,  4'd1,  12'd1950, 0,     1'b0, ST_OK},
        '{OP_DIFF, 5'd31, 4'd11, 12'd2000, 0,     1'b1, ST_BAD_DAY},
        '{OP_NOP,  5'd31, 4'd15, 12'd4095, -1,    1'b1, ST_OK},
        '{OP_LOAD, 5'd31, 4'd12, 12'd2049, 0,     1'b1, ST_OK},
        '{OP_ADD,  5'd0,  4'd0,  12'd0,   -36524, 1'b1, ST_OK}
    };

    initial begin
        int burst, offset, roll;
        t_opcode op;
        logic [4:0] d;
        logic [3:0] m;
        logic [11:0] y;
        n_fail = 0;
        date_day = 1; date_month = 1; date_year = 1950;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[i]) begin
            send_op(dir_table[i].op, dir_table[i].day, dir_table[i].month, dir_table[i].year,
                    dir_table[i].offset, dir_table[i].has_exp, dir_table[i].exp_status);
            if ($urandom_range(0, 2) == 0) sender_gap();
        end

        // drain fully once before the random part
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);

        for (int n = 0; n < 85; ) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && n < 85; k++, n++) begin
                roll = $urandom_range(0, 99);
                offset = 0;
                d = 5'($urandom_range(1, 28));
                m = 4'($urandom_range(1, 12));
                y = 12'($urandom_range(1950, 2049));
                if (roll < 10) begin
                    d = 5'($urandom()); m = 4'($urandom()); y = 12'($urandom());
                end else if (roll < 15) begin
                    d = 5'($urandom_range(29, 31));
                end
                roll = $urandom_range(0, 99);
                if (roll < 30) op = OP_LOAD;
                else if (roll < 65) op = OP_ADD;
                else if (roll < 95) op = OP_DIFF;
                else op = OP_NOP;
                roll = $urandom_range(0, 9);
                if (roll < 6) offset = $urandom_range(0, 800) - 400;
                else if (roll < 9) offset = $urandom_range(0, 80000) - 40000;
                else offset = $urandom_range(0, 1) ? 65535 : -65536;
                send_op(op, d, m, y, offset, 1'b0, ST_OK);
            end
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (6000) @(negedge i_clk);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/cda_pkg.sv
rtl/cda_datapath.sv
rtl/cda_ctrl.sv
rtl/calendar_date_arithmetic_unit.sv
tb/tb_calendar_date_arithmetic_unit.sv
